>>> rtl/core/mbc1_bank_controller_unit_defines.svh
// Assertion macros shared by the bank controller RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef MBC1_BANK_CONTROLLER_UNIT_DEFINES_SVH
`define MBC1_BANK_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define MBC1_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbc1 same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define MBC1_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbc1 next-cycle check failed");
`else
`define MBC1_ASSERT_SAME(label, ante, cons)
`define MBC1_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/mbc1_pkg.sv
package mbc1_pkg;

    // Field widths
    localparam int BANK_W   = 7;
    localparam int COUNT_W  = 10;
    localparam int RAMCNT_W = 5;
    localparam int PAGES_W  = 6;
    localparam int PHYS_W   = 21;

    // Request from the sequencer to the remainder unit
    typedef struct packed {
        logic               start;
        logic [BANK_W-1:0]  dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    // Status from the remainder unit back to the sequencer
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [BANK_W-1:0] rem;
    } mod_sts_t;

endpackage

>>> rtl/core/mbc1_mod_unit.sv
// Restoring remainder unit: one dividend bit per cycle.
// A zero divisor returns the dividend unchanged.
module mbc1_mod_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  mbc1_pkg::mod_req_t req,
    output mbc1_pkg::mod_sts_t sts
);

    localparam int STEP_W = $clog2(mbc1_pkg::BANK_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(mbc1_pkg::BANK_W - 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [mbc1_pkg::BANK_W-1:0]  rem_reg;
    logic [mbc1_pkg::BANK_W-1:0]  bits_reg;
    logic [mbc1_pkg::COUNT_W-1:0] div_reg;

    logic [mbc1_pkg::BANK_W:0]    trial;
    logic [mbc1_pkg::COUNT_W-1:0] trial_ext;
    logic [mbc1_pkg::COUNT_W-1:0] diff;
    logic                         fits;

    // Shift in the next dividend bit and try the subtract
    always_comb
    begin
        trial     = {rem_reg, bits_reg[mbc1_pkg::BANK_W-1]};
        trial_ext = {{(mbc1_pkg::COUNT_W - mbc1_pkg::BANK_W - 1){1'b0}}, trial};
        diff      = trial_ext - div_reg;
        fits      = trial_ext >= div_reg;
    end

    // Run the division steps
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            rem_reg  <= '0;
            bits_reg <= '0;
            div_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                step_reg <= '0;
                div_reg  <= req.divisor;
                bits_reg <= req.dividend;
                if (req.divisor == '0)
                begin
                    rem_reg  <= req.dividend;
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    rem_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[mbc1_pkg::BANK_W-1:0] : trial[mbc1_pkg::BANK_W-1:0];
                bits_reg <= {bits_reg[mbc1_pkg::BANK_W-2:0], 1'b0};
                step_reg <= step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.rem  = rem_reg;

endmodule

>>> rtl/core/mbc1_bank_controller_unit.sv
// Cartridge bank controller. Each request on the slave stream is one bus access
// and yields exactly one result on the master stream: a physical ROM or RAM
// address, open bus, or a register-write acknowledge, plus the RAM enable flag.
// The block takes one request at a time. Reads, RAM writes, RAM enable writes
// and mode writes pass from S_EXEC straight to S_PUSH. ROM bank writes run the
// bank number through a shared 7-step remainder unit; a high-bits write with
// more than 31 ROM banks uses that unit too, and in mode 1 with more than 32
// uses it twice. With a ROM bank count of zero the unit returns the dividend.
// Configuration writes are always accepted (cfg_ready is tied high).
`include "mbc1_bank_controller_unit_defines.svh"

module mbc1_bank_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // bus_address[15:0], write_value[23:16]
    input  logic [0:0]  s_tuser,   // operation[0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // phys_address[20:0], ram_write[21],
                                   // data_out[29:22], ram_enabled_flag[30]
    output logic [1:0]  m_tuser,   // target[1:0]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam logic [1:0] TGT_ROM  = 2'd0;
    localparam logic [1:0] TGT_RAM  = 2'd1;
    localparam logic [1:0] TGT_OPEN = 2'd2;
    localparam logic [1:0] TGT_NONE = 2'd3;

    localparam logic [1:0] CFG_ROM_BANKS = 2'd0;
    localparam logic [1:0] CFG_RAM_BANKS = 2'd1;
    localparam logic [1:0] CFG_RAM_PAGES = 2'd2;

    localparam logic [1:0] REG_RAM_EN   = 2'd0;
    localparam logic [1:0] REG_LOW_BANK = 2'd1;
    localparam logic [1:0] REG_HIGH     = 2'd2;
    localparam logic [1:0] REG_MODE     = 2'd3;

    localparam logic [3:0] RAM_EN_OFF = 4'h0;
    localparam logic [3:0] RAM_EN_ON  = 4'hA;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_DIV, S_PUSH} state_t;
    typedef enum logic [1:0] {JOB_LOW, JOB_HIGH, JOB_LOWWIN} job_t;

    state_t state_reg;
    job_t   job_reg;

    logic                          op_reg;
    logic [15:0]                   addr_reg;
    logic [7:0]                    val_reg;

    logic [mbc1_pkg::COUNT_W-1:0]  rom_count_reg;
    logic [mbc1_pkg::RAMCNT_W-1:0] ram_count_reg;
    logic [mbc1_pkg::PAGES_W-1:0]  ram_pages_reg;

    logic [4:0]                    low_reg;
    logic [1:0]                    high_reg;
    logic                          mode_reg;
    logic                          ram_enable_reg;
    logic [1:0]                    ram_bank_reg;
    logic [mbc1_pkg::BANK_W-1:0]   lower_reg;
    logic [mbc1_pkg::BANK_W-1:0]   upper_reg;

    logic                          mod_start_reg;
    logic [mbc1_pkg::BANK_W-1:0]   mod_dividend_reg;

    logic [1:0]                    res_target_reg;
    logic [mbc1_pkg::PHYS_W-1:0]   res_phys_reg;
    logic                          res_rw_reg;
    logic [7:0]                    res_dout_reg;

    logic                          m_valid_reg;
    logic [31:0]                   m_data_reg;
    logic [1:0]                    m_user_reg;

    mbc1_pkg::mod_req_t            mod_req;
    mbc1_pkg::mod_sts_t            mod_sts;

    logic                          in_ram;
    logic                          cnt_gt31;
    logic                          cnt_gt32;
    logic [mbc1_pkg::BANK_W-1:0]   low_raw;
    logic [mbc1_pkg::BANK_W-1:0]   low_dividend;
    logic [mbc1_pkg::BANK_W-1:0]   high_raw;
    logic [mbc1_pkg::BANK_W-1:0]   high_dividend;
    logic [mbc1_pkg::BANK_W-1:0]   lowwin_dividend;
    logic                          out_free;

    // Decode the held request and form the bumped bank numbers
    always_comb
    begin
        in_ram          = (addr_reg[15:13] == 3'b101) &&
                          ({1'b0, addr_reg[12:8]} < ram_pages_reg);
        cnt_gt31        = rom_count_reg > 10'd31;
        cnt_gt32        = rom_count_reg > 10'd32;
        low_raw         = {high_reg, val_reg[4:0]};
        low_dividend    = (low_raw[4:0] == 5'd0) ? low_raw + 1'b1 : low_raw;
        high_raw        = {val_reg[1:0], low_reg};
        high_dividend   = (high_raw[4:0] == 5'd0) ? high_raw + 1'b1 : high_raw;
        lowwin_dividend = {val_reg[1:0], 5'd0};
        out_free        = !m_valid_reg || m_tready;
    end

    assign mod_req.start    = mod_start_reg;
    assign mod_req.dividend = mod_dividend_reg;
    assign mod_req.divisor  = rom_count_reg;

    mbc1_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .sts   (mod_sts)
    );

    // Sequence each request and hold the result stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            job_reg          <= JOB_LOW;
            op_reg           <= 1'b0;
            addr_reg         <= '0;
            val_reg          <= '0;
            rom_count_reg    <= 10'd2;
            ram_count_reg    <= '0;
            ram_pages_reg    <= 6'd32;
            low_reg          <= '0;
            high_reg         <= '0;
            mode_reg         <= 1'b0;
            ram_enable_reg   <= 1'b0;
            ram_bank_reg     <= '0;
            lower_reg        <= '0;
            upper_reg        <= 7'd1;
            mod_start_reg    <= 1'b0;
            mod_dividend_reg <= '0;
            res_target_reg   <= TGT_NONE;
            res_phys_reg     <= '0;
            res_rw_reg       <= 1'b0;
            res_dout_reg     <= '0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            m_user_reg       <= '0;
        end
        else
        begin
            mod_start_reg <= 1'b0;
            if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            // Take configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_ROM_BANKS: rom_count_reg <= cfg_data;
                    CFG_RAM_BANKS: ram_count_reg <= cfg_data[mbc1_pkg::RAMCNT_W-1:0];
                    CFG_RAM_PAGES: ram_pages_reg <= cfg_data[mbc1_pkg::PAGES_W-1:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= s_tuser[0];
                        addr_reg  <= s_tdata[15:0];
                        val_reg   <= s_tdata[23:16];
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    res_target_reg <= TGT_NONE;
                    res_phys_reg   <= '0;
                    res_rw_reg     <= 1'b0;
                    res_dout_reg   <= '0;
                    state_reg      <= S_PUSH;
                    if (op_reg)
                    begin
                        if (!addr_reg[15])
                        begin
                            unique case (addr_reg[14:13])
                                REG_RAM_EN:
                                begin
                                    if (val_reg[3:0] == RAM_EN_OFF)
                                    begin
                                        ram_enable_reg <= 1'b0;
                                    end
                                    else if (val_reg[3:0] == RAM_EN_ON)
                                    begin
                                        ram_enable_reg <= 1'b1;
                                    end
                                end
                                REG_LOW_BANK:
                                begin
                                    mod_start_reg    <= 1'b1;
                                    mod_dividend_reg <= low_dividend;
                                    job_reg          <= JOB_LOW;
                                    state_reg        <= S_DIV;
                                end
                                REG_HIGH:
                                begin
                                    if (!mode_reg || cnt_gt31)
                                    begin
                                        lower_reg <= '0;
                                        if (cnt_gt31)
                                        begin
                                            mod_start_reg    <= 1'b1;
                                            mod_dividend_reg <= high_dividend;
                                            job_reg          <= JOB_HIGH;
                                            state_reg        <= S_DIV;
                                        end
                                    end
                                    if (mode_reg && ram_count_reg > 5'd1)
                                    begin
                                        ram_bank_reg <= val_reg[1:0];
                                    end
                                end
                                REG_MODE:
                                begin
                                    mode_reg <= val_reg[0];
                                    if (!val_reg[0])
                                    begin
                                        ram_bank_reg <= '0;
                                    end
                                    else
                                    begin
                                        high_reg  <= '0;
                                        upper_reg <= {2'b00, low_reg};
                                    end
                                end
                                default: ;
                            endcase
                        end
                        else if (in_ram)
                        begin
                            res_target_reg <= TGT_RAM;
                            res_phys_reg   <= {6'd0, ram_bank_reg, addr_reg[12:0]};
                            res_rw_reg     <= 1'b1;
                            res_dout_reg   <= val_reg;
                        end
                    end
                    else
                    begin
                        if (addr_reg[15:14] == 2'b00)
                        begin
                            res_target_reg <= TGT_ROM;
                            res_phys_reg   <= {lower_reg, addr_reg[13:0]};
                        end
                        else if (addr_reg[15:14] == 2'b01)
                        begin
                            res_target_reg <= TGT_ROM;
                            res_phys_reg   <= {upper_reg, addr_reg[13:0]};
                        end
                        else if (in_ram)
                        begin
                            res_target_reg <= TGT_RAM;
                            res_phys_reg   <= {6'd0, ram_bank_reg, addr_reg[12:0]};
                        end
                        else
                        begin
                            res_target_reg <= TGT_OPEN;
                            res_dout_reg   <= 8'hFF;
                        end
                    end
                end

                S_DIV:
                begin
                    if (mod_sts.done)
                    begin
                        state_reg <= S_PUSH;
                        unique case (job_reg)
                            JOB_LOW:
                            begin
                                low_reg   <= mod_sts.rem[4:0];
                                upper_reg <= mod_sts.rem;
                            end
                            JOB_HIGH:
                            begin
                                high_reg  <= mod_sts.rem[6:5];
                                upper_reg <= mod_sts.rem;
                                if (mode_reg && cnt_gt32)
                                begin
                                    mod_start_reg    <= 1'b1;
                                    mod_dividend_reg <= lowwin_dividend;
                                    job_reg          <= JOB_LOWWIN;
                                    state_reg        <= S_DIV;
                                end
                            end
                            JOB_LOWWIN:
                            begin
                                lower_reg <= mod_sts.rem;
                            end
                            default: ;
                        endcase
                    end
                end

                S_PUSH:
                begin
                    if (out_free)
                    begin
                        m_valid_reg <= 1'b1;
                        m_user_reg  <= res_target_reg;
                        m_data_reg  <= {1'b0, ram_enable_reg, res_dout_reg,
                                        res_rw_reg, res_phys_reg};
                        state_reg   <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    `MBC1_ASSERT_NEXT(a_accept_to_exec, s_tvalid && s_tready, state_reg == S_EXEC)
    `MBC1_ASSERT_SAME(a_done_in_div, mod_sts.done, state_reg == S_DIV)
    `MBC1_ASSERT_SAME(a_idle_unit_quiet, state_reg == S_IDLE, !mod_sts.busy && !mod_sts.done)
    `MBC1_ASSERT_SAME(a_rem_below_count, mod_sts.done && (rom_count_reg != '0), {3'b000, mod_sts.rem} < rom_count_reg)

endmodule
